// ----- hdl/adaptive_disturbance_estimator_core_assert.svh -----
// Assertion macros used by the estimator core.
`ifndef ADAPTIVE_DISTURBANCE_ESTIMATOR_CORE_ASSERT_SVH
`define ADAPTIVE_DISTURBANCE_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ADE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ADE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ade_pkg.sv -----
package ade_pkg;

  localparam int MAX_AXES = 6;
  localparam int QW       = 32;
  localparam int GW       = 31;
  localparam int ACC_W    = 60;
  localparam int PROD_W   = 64;
  localparam int SAT_IN_W = 66;
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = 5;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;

  localparam logic [2:0] CFG_NORM_BOUND   = 3'd6;
  localparam logic [2:0] CFG_BOUND_MARGIN = 3'd7;

  typedef enum logic [3:0] {
    LOP_IDLE, LOP_LOAD, LOP_WS, LOP_MUL_WS, LOP_YA, LOP_SQ, LOP_YE, LOP_YE_DONE,
    LOP_CORR, LOP_U, LOP_STEP, LOP_UPD, LOP_OUT_MUL, LOP_OUT
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     sel;   // 0: alpha estimate, 1: beta estimate
  } lane_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WS, ST_MUL_WS, ST_YA, ST_SQ, ST_YE, ST_YE_DONE, ST_PROJ, ST_PWAIT,
    ST_CORR, ST_U, ST_STEP, ST_UPD, ST_OUT_MUL, ST_OUT, ST_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    P_IDLE, P_COND, P_TEST, P_DIV1, P_DIV2, P_DIV3, P_KMUL, P_KSAT
  } proj_state_t;

  typedef struct packed {
    logic                 done;
    logic                 clip;
    logic signed [QW-1:0] k;
  } proj_res_t;

  typedef struct packed {
    logic          done;
    logic          ovf;
    logic [GW-1:0] q;
  } div_res_t;

  typedef struct packed {
    logic                 ov;
    logic signed [QW-1:0] v;
  } sat_t;

  // Clip a wide signed value to the 32-bit range.
  function automatic sat_t sat32(input logic signed [SAT_IN_W-1:0] x);
    sat_t res;
    res.ov = 1'b0;
    res.v  = x[QW-1:0];
    if (x[SAT_IN_W-1:QW-1] != {(SAT_IN_W-QW+1){x[SAT_IN_W-1]}}) begin
      res.ov = 1'b1;
      res.v  = x[SAT_IN_W-1] ? Q_MIN : Q_MAX;
    end
    return res;
  endfunction

endpackage

// ----- hdl/ade_lane.sv -----
module ade_lane import ade_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctl_t            ctl,
  input  logic signed [QW-1:0] pos,
  input  logic signed [QW-1:0] vel,
  input  logic [GW-1:0]        gain,
  input  logic signed [QW-1:0] k,
  output logic [ACC_W-1:0]     sq,
  output logic [ACC_W-1:0]     ye,
  output logic signed [QW-1:0] r,
  output logic                 clip
);

  logic signed [QW-1:0] p, v, w, s, ya, alpha, beta, u;
  logic signed [PROD_W-1:0] prod, mprod, prod_sh;
  logic signed [QW-1:0] e, y, ma, mb;
  logic signed [QW:0] p_ext, v_ext, ap, av;
  logic signed [34:0] w35, s35;
  sat_t w_sat, s_sat, ya_sat, u_sat, upd_sat, r_sat;

  assign e = ctl.sel ? beta : alpha;
  assign y = ctl.sel ? s : ya;
  assign prod_sh = prod >>> FRAC_BITS;

  assign p_ext = (QW+1)'(p);
  assign v_ext = (QW+1)'(v);
  assign ap = p_ext[QW] ? -p_ext : p_ext;
  assign av = v_ext[QW] ? -v_ext : v_ext;
  assign w35 = (35'(ap) <<< 1) + 35'(ap) + 35'(av);
  assign s35 = (35'(p) <<< 1) + 35'(p) + 35'(v);

  assign w_sat   = sat32(SAT_IN_W'(w35));
  assign s_sat   = sat32(SAT_IN_W'(s35));
  assign ya_sat  = sat32(SAT_IN_W'(prod_sh));
  assign u_sat   = sat32(SAT_IN_W'(y) - SAT_IN_W'(prod_sh));
  assign upd_sat = sat32(SAT_IN_W'(e) + SAT_IN_W'(prod_sh));
  assign r_sat   = sat32(SAT_IN_W'(prod_sh) + SAT_IN_W'(beta));

  always_comb begin
    ma = w;
    mb = s;
    case (ctl.op)
      LOP_SQ: begin
        ma = e;
        mb = e;
      end
      LOP_YE: begin
        ma = y;
        mb = e;
      end
      LOP_CORR: begin
        ma = e;
        mb = k;
      end
      LOP_STEP: begin
        ma = $signed({1'b0, gain});
        mb = u;
      end
      LOP_OUT_MUL: begin
        ma = w;
        mb = alpha;
      end
      default: begin
        ma = w;
        mb = s;
      end
    endcase
  end

  assign mprod = ma * mb;

  // Estimates are kept state and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= '0;
      beta  <= '0;
      clip  <= 1'b0;
    end else begin
      case (ctl.op)
        LOP_LOAD: clip <= 1'b0;
        LOP_WS:   clip <= clip | w_sat.ov | s_sat.ov;
        LOP_YA:   clip <= clip | ya_sat.ov;
        LOP_U:    clip <= clip | u_sat.ov;
        LOP_UPD: begin
          clip <= clip | upd_sat.ov;
          if (ctl.sel) begin
            beta <= upd_sat.v;
          end else begin
            alpha <= upd_sat.v;
          end
        end
        LOP_OUT:  clip <= clip | r_sat.ov;
        default:  clip <= clip;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      LOP_LOAD: begin
        p <= pos;
        v <= vel;
      end
      LOP_WS: begin
        w <= w_sat.v;
        s <= s_sat.v;
      end
      LOP_MUL_WS:  prod <= mprod;
      LOP_YA:      ya <= ya_sat.v;
      LOP_SQ:      prod <= mprod;
      LOP_YE: begin
        sq   <= ACC_W'(prod_sh);
        prod <= mprod;
      end
      LOP_YE_DONE: ye <= ACC_W'(prod_sh);
      LOP_CORR:    prod <= mprod;
      LOP_U:       u <= u_sat.v;
      LOP_STEP:    prod <= mprod;
      LOP_OUT_MUL: prod <= mprod;
      LOP_OUT:     r <= r_sat.v;
      default:     prod <= prod;
    endcase
  end

endmodule

// ----- hdl/ade_div.sv -----
module ade_div import ade_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [ACC_W-1:0] num,
  input  logic [ACC_W-1:0] den,
  output div_res_t         res
);

  logic [ACC_W-1:0] r, d;
  logic [GW-1:0] x, q;
  logic [DIV_CNT_W-1:0] cnt;
  logic busy, done, ovf;
  logic [ACC_W+GW-1:0] num_w, lim_w, x_w;
  logic [ACC_W:0] rs;
  logic take;

  // Quotient of num * 2^F / den reaches 2^31 exactly when num >= den * 2^(31-F).
  assign num_w = (ACC_W+GW)'(num);
  assign lim_w = {den, {GW{1'b0}}} >> FRAC_BITS;
  assign x_w   = {num, {GW{1'b0}}} >> (GW - FRAC_BITS);

  assign rs   = {r, x[GW-1]};
  assign take = rs >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (go && (num_w >= lim_w)) || (!go && busy && cnt == DIV_CNT_W'(1));
      if (go) begin
        busy <= !(num_w >= lim_w);
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ovf <= num_w >= lim_w;
      q   <= num_w >= lim_w ? GW'(Q_MAX) : '0;
      r   <= num >> (GW - FRAC_BITS);
      x   <= x_w[GW-1:0];
      d   <= den;
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      r   <= take ? ACC_W'(rs - {1'b0, d}) : rs[ACC_W-1:0];
      x   <= {x[GW-2:0], 1'b0};
      q   <= {q[GW-2:0], take};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.q    = q;

endmodule

// ----- hdl/ade_proj.sv -----
module ade_proj import ade_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [MAX_AXES-1:0][ACC_W-1:0]  sq,
  input  logic [MAX_AXES-1:0][ACC_W-1:0]  ye,
  input  logic [GW-1:0]                   norm_bound,
  input  logic [GW-1:0]                   bound_margin,
  output proj_res_t                       res
);

  proj_state_t state, state_next;
  logic [ACC_W-1:0] n_sum, t_val, n_total, t_raw;
  logic signed [ACC_W-1:0] d_sum, d_total;
  logic [2*GW-1:0] tprod, kprod, kk;
  logic [GW-1:0] f, g, eps;
  logic signed [QW-1:0] k;
  logic clip, done;
  logic div_go;
  logic [ACC_W-1:0] div_num, div_den;
  div_res_t dres;
  logic active;

  always_comb begin
    n_total = '0;
    d_total = '0;
    for (int i = 0; i < MAX_AXES; i++) begin
      n_total = n_total + sq[i];
      d_total = d_total + $signed(ye[i]);
    end
  end

  assign eps    = (bound_margin == '0) ? GW'(1) : bound_margin;
  assign t_raw  = ACC_W'(tprod >> FRAC_BITS);
  assign active = (n_sum > t_val) && !d_sum[ACC_W-1] && (d_sum != '0);
  assign kk     = kprod >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go  = 1'b0;
    div_num = n_sum - t_val;
    div_den = t_val;
    case (state)
      P_IDLE: if (start) state_next = P_COND;
      P_COND: state_next = P_TEST;
      P_TEST: begin
        if (active) begin
          div_go = 1'b1;
          state_next = P_DIV1;
        end else begin
          state_next = P_IDLE;
        end
      end
      P_DIV1: begin
        div_num = ACC_W'(dres.q);
        div_den = ACC_W'(eps);
        if (dres.done) begin
          div_go = 1'b1;
          state_next = P_DIV2;
        end
      end
      P_DIV2: begin
        div_num = d_sum;
        div_den = n_sum;
        if (dres.done) begin
          div_go = 1'b1;
          state_next = P_DIV3;
        end
      end
      P_DIV3: if (dres.done) state_next = P_KMUL;
      P_KMUL: state_next = P_KSAT;
      P_KSAT: state_next = P_IDLE;
      default: state_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      clip <= 1'b0;
    end else begin
      done <= ((state == P_TEST) && !active) || (state == P_KSAT);
      case (state)
        P_IDLE: if (start) clip <= 1'b0;
        P_DIV1, P_DIV2, P_DIV3: if (dres.done) clip <= clip | dres.ovf;
        P_KSAT: clip <= clip | (kk[2*GW-1:GW] != '0);
        default: clip <= clip;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      P_IDLE: begin
        n_sum <= n_total;
        d_sum <= d_total;
        tprod <= norm_bound * norm_bound;
      end
      P_COND: t_val <= (t_raw == '0) ? ACC_W'(1) : t_raw;
      P_TEST: if (!active) k <= '0;
      P_DIV2: if (dres.done) f <= dres.q;
      P_DIV3: if (dres.done) g <= dres.q;
      P_KMUL: kprod <= f * g;
      P_KSAT: k <= (kk[2*GW-1:GW] != '0) ? Q_MAX : $signed({1'b0, kk[GW-1:0]});
      default: k <= k;
    endcase
  end

  ade_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (div_num),
    .den (div_den),
    .res (dres)
  );

  assign res.done = done;
  assign res.clip = clip;
  assign res.k    = k;

endmodule

// ----- hdl/adaptive_disturbance_estimator_core.sv -----
// Channel  | Handshake              | Beat contents
// ---------+------------------------+----------------------------------------------
// input    | in_valid / in_stall    | pos_err_0..5, vel_err_0..5 (Q16.16 errors)
// output   | out_valid / out_stall  | dist_0..5 (Q16.16), saturated flag
// config   | cfg_we                 | cfg_index selects gain_0..5, bound, margin
//
// One beat is worked on at a time; a new beat is accepted only once the last result
// has left the emit state. Each projection that fires adds three divides on the
// shared one bit per cycle divider plus the product and clip steps; an overflowing
// divide skips its bit steps and returns the largest quotient. Reset is synchronous
// and clears the estimates and gains, loads the default bound and margin, and clears
// the handshake state; a stalled result holds the sequencer in its emit state.
`include "adaptive_disturbance_estimator_core_assert.svh"

module adaptive_disturbance_estimator_core import ade_pkg::*; #(
  parameter int AXES      = 6,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [QW-1:0] pos_err_0,
  input  logic signed [QW-1:0] pos_err_1,
  input  logic signed [QW-1:0] pos_err_2,
  input  logic signed [QW-1:0] pos_err_3,
  input  logic signed [QW-1:0] pos_err_4,
  input  logic signed [QW-1:0] pos_err_5,
  input  logic signed [QW-1:0] vel_err_0,
  input  logic signed [QW-1:0] vel_err_1,
  input  logic signed [QW-1:0] vel_err_2,
  input  logic signed [QW-1:0] vel_err_3,
  input  logic signed [QW-1:0] vel_err_4,
  input  logic signed [QW-1:0] vel_err_5,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [QW-1:0] dist_0,
  output logic signed [QW-1:0] dist_1,
  output logic signed [QW-1:0] dist_2,
  output logic signed [QW-1:0] dist_3,
  output logic signed [QW-1:0] dist_4,
  output logic signed [QW-1:0] dist_5,
  output logic                 saturated,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [GW-1:0]        cfg_data
);

  seq_state_t state, state_next;
  lane_ctl_t  ctl;
  logic       est_sel;
  logic       accept, emit, proj_start, clip_acc;
  proj_res_t  pres;

  logic [GW-1:0] gain [MAX_AXES];
  logic [GW-1:0] norm_bound, bound_margin;

  logic signed [QW-1:0] pos_arr [MAX_AXES];
  logic signed [QW-1:0] vel_arr [MAX_AXES];
  logic signed [QW-1:0] lane_r  [MAX_AXES];
  logic [MAX_AXES-1:0]  lane_clip;
  logic [MAX_AXES-1:0][ACC_W-1:0] lane_sq, lane_ye;

  assign pos_arr = '{pos_err_0, pos_err_1, pos_err_2, pos_err_3, pos_err_4, pos_err_5};
  assign vel_arr = '{vel_err_0, vel_err_1, vel_err_2, vel_err_3, vel_err_4, vel_err_5};

  // Configuration registers; any index maps onto one of the eight registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        gain[i] <= '0;
      end
      norm_bound   <= GW'(65536);
      bound_margin <= GW'(6554);
    end else if (cfg_we) begin
      if (cfg_index == CFG_NORM_BOUND) begin
        norm_bound <= cfg_data;
      end else if (cfg_index == CFG_BOUND_MARGIN) begin
        bound_margin <= cfg_data;
      end else begin
        gain[cfg_index] <= cfg_data;
      end
    end
  end

  // The sequencer walks every lane through the same steps: form weight and signal,
  // then for alpha and then beta the norm terms, the projection and the update,
  // and finally the disturbance product.
  assign accept = in_valid && !in_stall;
  assign emit   = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = LOP_IDLE;
    ctl.sel    = est_sel;
    proj_start = 1'b0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.op = LOP_LOAD;
          state_next = ST_WS;
        end
      end
      ST_WS: begin
        ctl.op = LOP_WS;
        state_next = ST_MUL_WS;
      end
      ST_MUL_WS: begin
        ctl.op = LOP_MUL_WS;
        state_next = ST_YA;
      end
      ST_YA: begin
        ctl.op = LOP_YA;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        ctl.op = LOP_SQ;
        state_next = ST_YE;
      end
      ST_YE: begin
        ctl.op = LOP_YE;
        state_next = ST_YE_DONE;
      end
      ST_YE_DONE: begin
        ctl.op = LOP_YE_DONE;
        state_next = ST_PROJ;
      end
      ST_PROJ: begin
        proj_start = 1'b1;
        state_next = ST_PWAIT;
      end
      ST_PWAIT: if (pres.done) state_next = ST_CORR;
      ST_CORR: begin
        ctl.op = LOP_CORR;
        state_next = ST_U;
      end
      ST_U: begin
        ctl.op = LOP_U;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        ctl.op = LOP_STEP;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        ctl.op = LOP_UPD;
        state_next = est_sel ? ST_OUT_MUL : ST_SQ;
      end
      ST_OUT_MUL: begin
        ctl.op = LOP_OUT_MUL;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        ctl.op = LOP_OUT;
        state_next = ST_EMIT;
      end
      ST_EMIT: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control flags and the output register. The output beat holds while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_sel   <= 1'b0;
      clip_acc  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        est_sel  <= 1'b0;
        clip_acc <= 1'b0;
      end else begin
        if (state == ST_UPD) begin
          est_sel <= 1'b1;
        end
        if (pres.done) begin
          clip_acc <= clip_acc | pres.clip;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dist_0    <= lane_r[0];
      dist_1    <= lane_r[1];
      dist_2    <= lane_r[2];
      dist_3    <= lane_r[3];
      dist_4    <= lane_r[4];
      dist_5    <= lane_r[5];
      saturated <= clip_acc | (|lane_clip);
    end
  end

  // One lane per active axis; axes beyond AXES report zero and never clip.
  for (genvar i = 0; i < MAX_AXES; i++) begin : g_lane
    if (i < AXES) begin : g_on
      ade_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .pos  (pos_arr[i]),
        .vel  (vel_arr[i]),
        .gain (gain[i]),
        .k    (pres.k),
        .sq   (lane_sq[i]),
        .ye   (lane_ye[i]),
        .r    (lane_r[i]),
        .clip (lane_clip[i])
      );
    end else begin : g_off
      assign lane_sq[i]   = '0;
      assign lane_ye[i]   = '0;
      assign lane_r[i]    = '0;
      assign lane_clip[i] = 1'b0;
    end
  end

  // Merge stage: sums the lane norm terms and computes the projection factor.
  ade_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk          (clk),
    .rst          (rst),
    .start        (proj_start),
    .sq           (lane_sq),
    .ye           (lane_ye),
    .norm_bound   (norm_bound),
    .bound_margin (bound_margin),
    .res          (pres)
  );

  `ADE_ASSERT_NOW(a_proj_done_in_wait, clk, rst, pres.done, state == ST_PWAIT, "projection finished outside its wait state")
  `ADE_ASSERT_NOW(a_out_rise_from_emit, clk, rst, $rose(out_valid), $past(state) == ST_EMIT, "output beat raised without an emit")
  `ADE_ASSERT_NEXT(a_beta_before_output, clk, rst, state == ST_OUT_MUL, est_sel, "output product started before the beta update")

endmodule

// ----- sim/adaptive_disturbance_estimator_core_tb.sv -----
`timescale 1ns / 1ps

module adaptive_disturbance_estimator_core_tb;
  import ade_pkg::*;

  localparam int FB = 16;
  localparam longint QHI = 64'sd2147483647;
  localparam longint QLO = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [MAX_AXES-1:0][QW-1:0] vals;
    logic                        sat;
  } dist_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [QW-1:0] pos_err_0 = '0, pos_err_1 = '0, pos_err_2 = '0;
  logic signed [QW-1:0] pos_err_3 = '0, pos_err_4 = '0, pos_err_5 = '0;
  logic signed [QW-1:0] vel_err_0 = '0, vel_err_1 = '0, vel_err_2 = '0;
  logic signed [QW-1:0] vel_err_3 = '0, vel_err_4 = '0, vel_err_5 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [QW-1:0] dist_0, dist_1, dist_2, dist_3, dist_4, dist_5;
  logic saturated;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [GW-1:0] cfg_data = '0;

  adaptive_disturbance_estimator_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_err_0(pos_err_0), .pos_err_1(pos_err_1), .pos_err_2(pos_err_2),
    .pos_err_3(pos_err_3), .pos_err_4(pos_err_4), .pos_err_5(pos_err_5),
    .vel_err_0(vel_err_0), .vel_err_1(vel_err_1), .vel_err_2(vel_err_2),
    .vel_err_3(vel_err_3), .vel_err_4(vel_err_4), .vel_err_5(vel_err_5),
    .out_valid(out_valid), .out_stall(out_stall),
    .dist_0(dist_0), .dist_1(dist_1), .dist_2(dist_2),
    .dist_3(dist_3), .dist_4(dist_4), .dist_5(dist_5),
    .saturated(saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // The clock runs 4 ns high and 4 ns low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block's registers and estimates used by the predictor.
  longint gain_sh[MAX_AXES];
  longint bound_sh;
  longint margin_sh;
  longint alpha_sh[MAX_AXES];
  longint beta_sh[MAX_AXES];
  bit     step_clipped;

  dist_beat_t dist_pending[$];
  int         send_idle_pct;
  int         recv_idle_pct;
  int         fail_count = 0;
  longint     cycle_count = 0;

  // Clip to the 32-bit range and remember that a clip happened in this beat.
  function automatic longint clip_q(longint x);
    if (x > QHI) begin
      step_clipped = 1'b1;
      return QHI;
    end
    if (x < QLO) begin
      step_clipped = 1'b1;
      return QLO;
    end
    return x;
  endfunction

  // Fixed-point divide floor(num * 2^FB / den), clipped to the largest positive value.
  function automatic longint fix_div(longint num, longint den);
    longint unsigned q;
    longint unsigned r;
    q = longint'(num) / den;
    r = longint'(num) % den;
    if (q > (QHI >> FB)) begin
      step_clipped = 1'b1;
      return QHI;
    end
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = (q << 1) | 1;
      end else begin
        q = q << 1;
      end
    end
    return longint'(q);
  endfunction

  // Advance one estimate by the adaptation vector, with norm projection.
  function automatic void adapt_estimate(bit is_beta, longint y[MAX_AXES]);
    longint e[MAX_AXES];
    longint n_sq, t_sq, dir, f, g, k, corr, u, stp;
    n_sq = 0;
    dir  = 0;
    k    = 0;
    for (int i = 0; i < MAX_AXES; i++) begin
      e[i] = is_beta ? beta_sh[i] : alpha_sh[i];
      n_sq += (e[i] * e[i]) >>> FB;
      dir  += (y[i] * e[i]) >>> FB;
    end
    t_sq = (bound_sh * bound_sh) >>> FB;
    if (t_sq == 0) t_sq = 1;
    if (n_sq > t_sq && dir > 0) begin
      f = fix_div(fix_div(n_sq - t_sq, t_sq), (margin_sh == 0) ? 1 : margin_sh);
      g = fix_div(dir, n_sq);
      k = clip_q((f * g) >>> FB);
    end
    for (int i = 0; i < MAX_AXES; i++) begin
      corr = (e[i] * k) >>> FB;
      u    = clip_q(y[i] - corr);
      stp  = (gain_sh[i] * u) >>> FB;
      if (is_beta) beta_sh[i] = clip_q(e[i] + stp);
      else alpha_sh[i] = clip_q(e[i] + stp);
    end
  endfunction

  // Work out the disturbance beat that one error beat produces.
  function automatic dist_beat_t predict_dist(longint p[MAX_AXES], longint v[MAX_AXES]);
    longint w[MAX_AXES], ya[MAX_AXES], yb[MAX_AXES];
    longint s;
    dist_beat_t res;
    step_clipped = 1'b0;
    for (int i = 0; i < MAX_AXES; i++) begin
      w[i]  = clip_q(3 * (p[i] < 0 ? -p[i] : p[i]) + (v[i] < 0 ? -v[i] : v[i]));
      s     = clip_q(3 * p[i] + v[i]);
      ya[i] = clip_q((w[i] * s) >>> FB);
      yb[i] = s;
    end
    adapt_estimate(1'b0, ya);
    adapt_estimate(1'b1, yb);
    for (int i = 0; i < MAX_AXES; i++)
      res.vals[i] = QW'(clip_q(((w[i] * alpha_sh[i]) >>> FB) + beta_sh[i]));
    res.sat = step_clipped;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("t=%0t %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Receiver: stalls at random with the current percentage.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker: each accepted output beat is matched against the oldest prediction.
  always @(posedge clk) begin
    dist_beat_t want;
    logic signed [QW-1:0] got[MAX_AXES];
    if (!rst && out_valid && !out_stall) begin
      got = '{dist_0, dist_1, dist_2, dist_3, dist_4, dist_5};
      if (dist_pending.size() == 0) begin
        report_mismatch("output beat with nothing pending", 1, 0);
      end else begin
        want = dist_pending.pop_front();
        for (int i = 0; i < MAX_AXES; i++)
          if (got[i] !== $signed(want.vals[i]))
            report_mismatch($sformatf("dist_%0d", i), longint'(got[i]),
                            longint'($signed(want.vals[i])));
        if (saturated !== want.sat)
          report_mismatch("saturated", longint'(saturated), longint'(want.sat));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one error beat. The valid stays high on return; an idle gap or a drain lowers it.
  task automatic send_errors(longint p[MAX_AXES], longint v[MAX_AXES]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pos_err_0 <= QW'(p[0]); pos_err_1 <= QW'(p[1]); pos_err_2 <= QW'(p[2]);
    pos_err_3 <= QW'(p[3]); pos_err_4 <= QW'(p[4]); pos_err_5 <= QW'(p[5]);
    vel_err_0 <= QW'(v[0]); vel_err_1 <= QW'(v[1]); vel_err_2 <= QW'(v[2]);
    vel_err_3 <= QW'(v[3]); vel_err_4 <= QW'(v[4]); vel_err_5 <= QW'(v[5]);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dist_pending.push_back(predict_dist(p, v));
  endtask

  // Stop sending and wait until every predicted beat has come out, then let the block settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (dist_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back; only called while the block is idle.
  task automatic program_regs(longint g[MAX_AXES], longint bound, longint margin);
    for (int i = 0; i < MAX_AXES; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= GW'(g[i]);
      gain_sh[i] = g[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NORM_BOUND;
    cfg_data  <= GW'(bound);
    bound_sh  = bound;
    @(posedge clk);
    cfg_index <= CFG_BOUND_MARGIN;
    cfg_data  <= GW'(margin);
    margin_sh = margin;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Error values: most often a few units in Q16.16 so the estimates build up and the
  // projection fires, plus wide values, full-range words and the corners.
  function automatic longint rand_err();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
    if (pick < 70) return longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    if (pick < 90) return longint'($signed($urandom()));
    case ($urandom_range(4))
      0: return QHI;
      1: return QLO;
      2: return -1;
      3: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint rand_gain();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) return $urandom_range(0, 1 << 14);
    if (pick < 8) return $urandom_range(0, 1 << 18);
    return longint'($urandom()) & QHI;
  endfunction

  task automatic send_random(int count);
    longint p[MAX_AXES], v[MAX_AXES];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        p[i] = rand_err();
        v[i] = rand_err();
      end
      send_errors(p, v);
    end
  endtask

  // Gains at zero after reset: the estimates must hold at zero with the reset bound.
  task automatic test_reset_state();
    longint p[MAX_AXES], v[MAX_AXES];
    for (int i = 0; i < MAX_AXES; i++) begin
      p[i] = 1 << 16;
      v[i] = -(1 << 15);
    end
    send_errors(p, v);
    send_errors(v, p);
    drain_block();
  endtask

  // Field corners under the largest gains: saturation of weight, signal and estimates.
  task automatic test_field_extremes();
    longint g[MAX_AXES], p[MAX_AXES], v[MAX_AXES];
    longint corners[6];
    corners = '{QHI, QLO, 0, -1, 1, 1 << 16};
    for (int i = 0; i < MAX_AXES; i++) g[i] = QHI;
    program_regs(g, QHI, QHI);
    for (int a = 0; a < 6; a++)
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < MAX_AXES; i++) begin
          p[i] = corners[(a + i) % 6];
          v[i] = corners[(a + b + 2 * i) % 6];
        end
        send_errors(p, v);
      end
    drain_block();
  endtask

  // A bound whose square underflows to zero and a zero margin: the projection
  // must use the smallest threshold and divisor.
  task automatic test_tiny_bound();
    longint g[MAX_AXES], p[MAX_AXES], v[MAX_AXES];
    for (int i = 0; i < MAX_AXES; i++) g[i] = 1 << (12 + i);
    program_regs(g, 0, 0);
    for (int n = 0; n < 6; n++) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        p[i] = (n % 2) ? (1 << 17) : -(1 << 16);
        v[i] = (i + n) << 14;
      end
      send_errors(p, v);
    end
    drain_block();
    program_regs(g, 1, 1);
    send_random(6);
    drain_block();
  endtask

  // Random beats under random gains and margins, with one idling pattern per phase.
  task automatic test_random_phase(int s_pct, int r_pct, longint bound, int count);
    longint g[MAX_AXES];
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < MAX_AXES; i++) g[i] = rand_gain();
    program_regs(g, bound, $urandom_range(1, 1 << 17));
    send_random(count / 2);
    drain_block();
    for (int i = 0; i < MAX_AXES; i++) g[i] = rand_gain();
    program_regs(g, $urandom_range(1 << 12, 1 << 20), $urandom_range(1, 1 << 16));
    send_random(count - count / 2);
    drain_block();
  endtask

  initial begin
    send_idle_pct = 11;
    recv_idle_pct = 86;
    for (int i = 0; i < MAX_AXES; i++) begin
      gain_sh[i]  = 0;
      alpha_sh[i] = 0;
      beta_sh[i]  = 0;
    end
    bound_sh  = 65536;
    margin_sh = 6554;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_tiny_bound();
    test_random_phase(11, 86, 1, 410);
    test_random_phase(86, 11, QHI, 410);
    test_random_phase(0, 0, 1 << 16, 410);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ade_pkg.sv
hdl/ade_lane.sv
hdl/ade_div.sv
hdl/ade_proj.sv
hdl/adaptive_disturbance_estimator_core.sv
sim/adaptive_disturbance_estimator_core_tb.sv
